// ===== rtl/lgre_pkg.sv =====
// Shared types and constants for the life generation row engine.
// No dependencies; every other file in rtl/ imports this package.
package lgre_pkg;

  localparam int unsigned ROW_W       = 64;  // payload width of a row on the channels
  localparam int unsigned CFG_W       = 7;   // width of the column-count register
  localparam int unsigned NBR_W       = 4;   // holds a neighbor count of 0..8
  localparam int unsigned QUEUE_DEPTH = 3;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET   = 7'd64;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic [ROW_W-1:0] next_row_bits;
    logic             grid_done;
  } res_t;

endpackage

// ===== rtl/lgre_if.sv =====
// Valid/ready channel interfaces for the row input and the result output.
// Depends on lgre_pkg for the row width.
interface lgre_row_if;
  import lgre_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_bits;
  logic             last_row;

  modport source (output valid, output row_bits, output last_row, input ready);
  modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

interface lgre_res_if;
  import lgre_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] next_row_bits;
  logic             grid_done;

  modport source (output valid, output next_row_bits, output grid_done, input ready);
  modport sink   (input valid, input next_row_bits, input grid_done, output ready);
endinterface

// ===== rtl/lgre_lane.sv =====
// One column lane: B3/S23 rule on a 3x3 window of cells.
// Depends on lgre_pkg for the rule counts.
module lgre_lane import lgre_pkg::*; (
  input  logic [2:0] above_i,
  input  logic [2:0] mid_i,
  input  logic [2:0] below_i,
  input  logic       in_use_i,
  output logic       alive_o
);

  logic [NBR_W-1:0] nbr_cnt;

  assign nbr_cnt = NBR_W'(above_i[0]) + NBR_W'(above_i[1]) + NBR_W'(above_i[2])
                 + NBR_W'(mid_i[0])   + NBR_W'(mid_i[2])
                 + NBR_W'(below_i[0]) + NBR_W'(below_i[1]) + NBR_W'(below_i[2]);

  // columns past the configured width read as zero
  assign alive_o = in_use_i &
                   ((nbr_cnt == BIRTH_COUNT) || (mid_i[1] && (nbr_cnt == SURVIVE_COUNT)));

endmodule

// ===== rtl/lgre_row_unit.sv =====
// Next state of one row: a lane per column plus ghost-border padding and row assembly.
// Depends on lgre_pkg and lgre_lane.
module lgre_row_unit import lgre_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic [MAX_WIDTH-1:0] above_i,
  input  logic [MAX_WIDTH-1:0] mid_i,
  input  logic [MAX_WIDTH-1:0] below_i,
  input  logic [MAX_WIDTH-1:0] in_use_i,
  output logic [MAX_WIDTH-1:0] next_o
);

  logic [MAX_WIDTH+1:0] above_ext;
  logic [MAX_WIDTH+1:0] mid_ext;
  logic [MAX_WIDTH+1:0] below_ext;
  logic [MAX_WIDTH-1:0] lane_alive;

  // pad with live ghost cells left of column 0 and from the configured width on
  assign above_ext[0]           = 1'b1;
  assign mid_ext[0]             = 1'b1;
  assign below_ext[0]           = 1'b1;
  assign above_ext[MAX_WIDTH+1] = 1'b1;
  assign mid_ext[MAX_WIDTH+1]   = 1'b1;
  assign below_ext[MAX_WIDTH+1] = 1'b1;

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_col
    assign above_ext[k+1] = in_use_i[k] ? above_i[k] : 1'b1;
    assign mid_ext[k+1]   = in_use_i[k] ? mid_i[k]   : 1'b1;
    assign below_ext[k+1] = in_use_i[k] ? below_i[k] : 1'b1;

    lgre_lane u_lane (
      .above_i  (above_ext[k+2:k]),
      .mid_i    (mid_ext[k+2:k]),
      .below_i  (below_ext[k+2:k]),
      .in_use_i (in_use_i[k]),
      .alive_o  (lane_alive[k])
    );
  end

  assign next_o = lane_alive;

endmodule

// ===== rtl/lgre_out_queue.sv =====
// Three-entry result queue: takes up to two results per cycle, gives one.
// Depends on lgre_pkg for the result type.
module lgre_out_queue import lgre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  res_t              first_i,
  input  res_t              second_i,
  input  logic              pop_i,
  output res_t              head_o,
  output logic              valid_o,
  output logic              room_two_o
);

  res_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic [QPTR_W-1:0] wr_ptr_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign wr_ptr_nxt = ptr_inc(wr_ptr_q);

  always_comb begin
    case (push_cnt_i)
      2'd1:    wr_ptr_d = wr_ptr_nxt;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nxt);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = QCNT_W'(({1'b0, count_q} + {1'b0, push_cnt_i}) - {2'b00, pop_i});
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= first_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o     = mem_q[rd_ptr_q];
  assign valid_o    = (count_q != '0);
  assign room_two_o = (count_q <= QCNT_W'(1));

endmodule

// ===== rtl/life_generation_row_engine.sv =====
// Game of Life (B3/S23) generation engine, one grid row per transfer.
// Depends on lgre_pkg, lgre_if, lgre_row_unit and lgre_out_queue.
//
// Usage: stream the rows of a grid top to bottom on row_i, one row per
// transfer, bit j = column j, with last_row set on the final row. The grid
// is framed by live ghost cells on all four sides. The first row yields no
// result; each later row yields the next state of the row above it; the last
// row yields two results, the second with grid_done set. A single-row grid
// yields one result with grid_done set. Columns at and past width_in_use are
// ignored on input and read as zero on output.
// Latency: res_o.valid is set the cycle after a row transfer that yields a result.
// Throughput: one row per cycle while fewer than two results are waiting; both
// results of the last row are computed in that same cycle by two row units, and
// the three-entry result queue drops ready while two or more results are waiting.
// Stall: when res_o is held off the queue fills and row_i.ready drops once
// fewer than two slots are free; nothing is lost.
// Reset: rows held are cleared to the top ghost border, the queue is emptied
// and width_in_use returns to 64. Write width_in_use only while idle.
module life_generation_row_engine import lgre_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  lgre_row_if.sink         row_i,
  lgre_res_if.source       res_o
);

  logic [CFG_W-1:0]     width_q;
  logic [MAX_WIDTH-1:0] older_q, older_d;
  logic [MAX_WIDTH-1:0] middle_q, middle_d;
  logic                 held_q, held_d;

  logic [MAX_WIDTH-1:0] in_use;
  logic [MAX_WIDTH-1:0] row_m;
  logic [MAX_WIDTH-1:0] next_mid;
  logic [MAX_WIDTH-1:0] next_low;
  logic                 row_xfer;
  logic                 res_xfer;
  logic                 room_two;
  logic [1:0]           push_cnt;
  res_t                 first_res;
  res_t                 second_res;
  res_t                 head;

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_use
    assign in_use[k] = (width_q > CFG_W'(k));
  end

  assign row_m = row_i.row_bits[MAX_WIDTH-1:0] & in_use;

  // middle row between the two held rows and the incoming one
  lgre_row_unit #(.MAX_WIDTH(MAX_WIDTH)) u_unit_mid (
    .above_i  (older_q),
    .mid_i    (middle_q),
    .below_i  (row_m),
    .in_use_i (in_use),
    .next_o   (next_mid)
  );

  // incoming row against the bottom border; middle_q is all ones when no row is held
  lgre_row_unit #(.MAX_WIDTH(MAX_WIDTH)) u_unit_low (
    .above_i  (middle_q),
    .mid_i    (row_m),
    .below_i  ('1),
    .in_use_i (in_use),
    .next_o   (next_low)
  );

  assign row_i.ready = room_two;
  assign row_xfer    = row_i.valid && row_i.ready;
  assign res_xfer    = res_o.valid && res_o.ready;

  always_comb begin
    older_d    = older_q;
    middle_d   = middle_q;
    held_d     = held_q;
    push_cnt   = 2'd0;
    first_res  = '{next_row_bits: ROW_W'(next_low), grid_done: 1'b1};
    second_res = '{next_row_bits: ROW_W'(next_low), grid_done: 1'b1};
    if (row_xfer) begin
      if (held_q) begin
        first_res = '{next_row_bits: ROW_W'(next_mid), grid_done: 1'b0};
        push_cnt  = row_i.last_row ? 2'd2 : 2'd1;
      end else begin
        push_cnt  = row_i.last_row ? 2'd1 : 2'd0;
      end
      if (row_i.last_row) begin
        // back to the top border for the next grid
        older_d  = '1;
        middle_d = '1;
        held_d   = 1'b0;
      end else begin
        older_d  = middle_q;
        middle_d = row_m;
        held_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      older_q  <= '1;
      middle_q <= '1;
      held_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      older_q  <= older_d;
      middle_q <= middle_d;
      held_q   <= held_d;
    end
  end

  lgre_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .first_i    (first_res),
    .second_i   (second_res),
    .pop_i      (res_xfer),
    .head_o     (head),
    .valid_o    (res_o.valid),
    .room_two_o (room_two)
  );

  assign res_o.next_row_bits = head.next_row_bits;
  assign res_o.grid_done     = head.grid_done;

  a_border_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> (&middle_q))
    else $error("middle row not at ghost border while no row is held");

  a_last_row_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_xfer && row_i.last_row) |=> !held_q)
    else $error("held row survived the last row of a grid");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_xfer && (held_q || row_i.last_row)) |=> res_o.valid)
    else $error("row transfer that yields a result left the output empty");

endmodule

// ===== sim/tb_life_generation_row_engine.sv =====
// Testbench for life_generation_row_engine: streams grids row by row, predicts
// each next-generation row and checks every result transfer in order.
// Depends on lgre_pkg, lgre_if and the rtl/ sources of the engine.
`timescale 1ns / 1ps

module tb_life_generation_row_engine;
  import lgre_pkg::*;

  localparam int unsigned DUT_COLS        = 64;
  localparam int          STALL_LIMIT     = 2000;
  localparam int          PRESSURE_CYCLES = 300;
  localparam int          RANDOM_ROWS     = 400;
  localparam int          DRAIN_CYCLES    = 4;

  logic             clk;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lgre_row_if row_ch ();
  lgre_res_if res_ch ();

  life_generation_row_engine #(
    .MAX_WIDTH(DUT_COLS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .row_i      (row_ch),
    .res_o      (res_ch)
  );

  // Predictor state: the two rows held, whether one is held, the column count.
  logic [ROW_W-1:0] prev_above;
  logic [ROW_W-1:0] prev_middle;
  logic             row_held;
  logic [CFG_W-1:0] cols_reg;
  res_t             expected_rows[$];

  int  err_count;
  int  rows_sent;
  bit  idle_on;
  int  hold_req;
  int  hold_seen;
  int  hold_left;
  int  stall_left;
  int  quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int live_at(input logic [ROW_W-1:0] r, input int c, input int unsigned w);
    if (c < 0 || c >= int'(w)) begin
      return 1;
    end
    return int'(r[c]);
  endfunction

  function automatic logic [ROW_W-1:0] life_next(input logic [ROW_W-1:0] above,
                                                 input logic [ROW_W-1:0] mid,
                                                 input logic [ROW_W-1:0] below,
                                                 input int unsigned w);
    logic [ROW_W-1:0] nxt;
    int               n;
    nxt = '0;
    for (int j = 0; j < int'(w); j++) begin
      n = 0;
      for (int d = -1; d <= 1; d++) begin
        n += live_at(above, j + d, w) + live_at(below, j + d, w);
        if (d != 0) begin
          n += live_at(mid, j + d, w);
        end
      end
      if (n == int'(BIRTH_COUNT) || (live_at(mid, j, w) == 1 && n == int'(SURVIVE_COUNT))) begin
        nxt[j] = 1'b1;
      end
    end
    return nxt;
  endfunction

  task automatic predict_transfer(input logic [ROW_W-1:0] bits, input logic last);
    int unsigned      w;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] r;
    logic [ROW_W-1:0] ones;
    ones = '1;
    w    = (cols_reg > DUT_COLS) ? DUT_COLS : cols_reg;
    mask = (w >= ROW_W) ? '1 : ((64'd1 << w) - 64'd1);
    r    = bits & mask;
    if (!row_held) begin
      if (last) begin
        expected_rows.push_back('{next_row_bits: life_next(ones, r, ones, w) & mask,
                                  grid_done: 1'b1});
      end else begin
        prev_above  = ones;
        prev_middle = r;
        row_held    = 1'b1;
      end
    end else begin
      expected_rows.push_back('{next_row_bits: life_next(prev_above, prev_middle, r, w) & mask,
                                grid_done: 1'b0});
      if (last) begin
        expected_rows.push_back('{next_row_bits: life_next(prev_middle, r, ones, w) & mask,
                                  grid_done: 1'b1});
        prev_above  = ones;
        prev_middle = ones;
        row_held    = 1'b0;
      end else begin
        prev_above  = prev_middle;
        prev_middle = r;
      end
    end
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return a;
      1: return a & b;
      2: return a | b;
      default: return a & b & {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_row(input logic [ROW_W-1:0] bits, input logic last);
    int gap;
    row_ch.valid    <= 1'b1;
    row_ch.row_bits <= bits;
    row_ch.last_row <= last;
    @(posedge clk);
    while (!row_ch.ready) begin
      @(posedge clk);
    end
    predict_transfer(bits, last);
    rows_sent++;
    gap = (idle_on && $urandom_range(0, 99) < 35) ? gap_len() : 0;
    if (gap > 0) begin
      row_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_grid(input int rows);
    for (int i = 0; i < rows; i++) begin
      send_row(rand_row(), (i == rows - 1));
    end
  endtask

  // Drop valid, let every expected result arrive, then allow for latency.
  task automatic wait_drained();
    row_ch.valid <= 1'b0;
    while (expected_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] cols);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cols;
    @(posedge clk);
    cols_reg = cols;
    cfg_we <= 1'b0;
  endtask

  task automatic test_single_row_grids();
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row({32{2'b10}}, 1'b1);
  endtask

  task automatic test_extreme_rows();
    send_row('0, 1'b0);
    send_row('1, 1'b0);
    send_row('0, 1'b0);
    send_row('1, 1'b1);
    send_row({16{4'hA}}, 1'b0);
    send_row({16{4'h5}}, 1'b1);
  endtask

  task automatic test_blinker();
    set_width(7'd8);
    send_row(64'h00, 1'b0);
    send_row(64'h08, 1'b0);
    send_row(64'h08, 1'b0);
    send_row(64'h08, 1'b0);
    send_row(64'h00, 1'b1);
  endtask

  task automatic test_width_extremes();
    logic [CFG_W-1:0] widths[6];
    widths = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd65, 7'd63};
    foreach (widths[k]) begin
      set_width(widths[k]);
      send_row({$urandom, $urandom}, 1'b0);
      send_row({$urandom, $urandom}, 1'b1);
    end
    set_width(WIDTH_RESET);
  endtask

  task automatic test_random_grids();
    int               r;
    int               rows;
    logic [CFG_W-1:0] extremes[8];
    extremes = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127};
    rows_sent = 0;
    while (rows_sent < RANDOM_ROWS) begin
      if ($urandom_range(0, 99) < 30) begin
        if ($urandom_range(0, 3) == 0) begin
          set_width(extremes[$urandom_range(0, 7)]);
        end else begin
          set_width(CFG_W'($urandom_range(0, 127)));
        end
      end
      idle_on = ($urandom_range(0, 99) >= 20);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        rows = $urandom_range(1, 6);
      end else if (r < 95) begin
        rows = $urandom_range(7, 16);
      end else begin
        rows = $urandom_range(30, 40);
      end
      send_grid(rows);
    end
    idle_on = 1'b1;
  endtask

  // Hold the result side off while rows keep coming, so the input stalls.
  task automatic test_backpressure();
    wait_drained();
    idle_on  = 1'b0;
    hold_req <= hold_req + 1;
    send_grid(24);
    wait_drained();
    idle_on = 1'b1;
  endtask

  // Result side ready generator.
  always @(posedge clk) begin
    logic rdy;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = PRESSURE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 20) begin
      stall_left = gap_len() - 1;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    res_ch.ready <= rdy;
  end

  // Compare each result transfer against the oldest expected row.
  always @(posedge clk) begin
    res_t exp_row;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_rows.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result next_row_bits=%h grid_done=%b", $time,
                 res_ch.next_row_bits, res_ch.grid_done);
      end else begin
        exp_row = expected_rows.pop_front();
        if (res_ch.next_row_bits !== exp_row.next_row_bits) begin
          err_count++;
          $display("%0t: next_row_bits expected %h actual %h", $time,
                   exp_row.next_row_bits, res_ch.next_row_bits);
        end
        if (res_ch.grid_done !== exp_row.grid_done) begin
          err_count++;
          $display("%0t: grid_done expected %b actual %b", $time,
                   exp_row.grid_done, res_ch.grid_done);
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_ni || (row_ch.valid && row_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    row_ch.valid    <= 1'b0;
    row_ch.row_bits <= '0;
    row_ch.last_row <= 1'b0;
    prev_above   = '1;
    prev_middle  = '1;
    row_held     = 1'b0;
    cols_reg     = WIDTH_RESET;
    err_count    = 0;
    rows_sent    = 0;
    idle_on      = 1'b1;
    hold_req     = 0;
    hold_seen    = 0;
    hold_left    = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_single_row_grids();
    test_extreme_rows();
    test_blinker();
    test_width_extremes();
    test_random_grids();
    test_backpressure();
    wait_drained();

    if (err_count == 0 && expected_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lgre_pkg.sv
rtl/lgre_if.sv
rtl/lgre_lane.sv
rtl/lgre_row_unit.sv
rtl/lgre_out_queue.sv
rtl/life_generation_row_engine.sv
sim/tb_life_generation_row_engine.sv
